/* src/ter_pkg.sv */
`timescale 1ns / 1ps
// Shared constants for the triangle edge rasterizer.
// No dependencies; used by triangle_edge_rasterizer.
package ter_pkg;

    // Item opcodes
    localparam logic OPC_LOAD    = 1'b0;
    localparam logic OPC_ADVANCE = 1'b1;

    // Register index, taken from paddr[2]
    localparam logic REG_FB_WIDTH  = 1'b0;
    localparam logic REG_FB_HEIGHT = 1'b1;

    // Field widths
    localparam int VERT_W  = 16;
    localparam int COLOR_W = 32;
    localparam int ADDR_W  = 24;
    localparam int DIM_W   = 13;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Edge arithmetic widths
    localparam int STEP_W = VERT_W + 1;     // vertex difference
    localparam int OFS_W  = VERT_W + 2;     // box corner minus vertex
    localparam int PROD_W = OFS_W + STEP_W; // one product term
    localparam int EDGE_W = PROD_W + 1;     // edge value

    // Register reset values
    localparam logic [DIM_W-1:0] FB_WIDTH_RST  = 13'd800;
    localparam logic [DIM_W-1:0] FB_HEIGHT_RST = 13'd600;

    // Default clip limits
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

endpackage

/* src/triangle_edge_rasterizer.sv */
`timescale 1ns / 1ps
// Edge-function triangle rasterizer: box setup pipeline and pixel walker.
// Depends on ter_pkg.
//
// A load beat (opcode 0) sets up a triangle; each advance beat (opcode 1) tests the
// next pixel of the clipped bounding box in row-major order and returns one result
// beat with address, color, write flag and done flag. The block takes one item per
// clock while item_stall is low. An item passes three pipeline registers (input,
// bounding box, edge products) before it reaches the walker; an advance then fills
// the result register. Loads give no result. item_stall rises only when the result
// register holds a beat not yet taken and all three stages behind it are full. Write
// the configuration only while no item is in flight: the box stage reads the frame
// size for clipping and the walker reads the width for addresses.
module triangle_edge_rasterizer #(
    parameter int MAX_WIDTH  = ter_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ter_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // APB-style configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ter_pkg::PADDR_W-1:0]         paddr,
    input  logic [ter_pkg::PDATA_W-1:0]         pwdata,
    output logic [ter_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    // Item channel
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                opcode,
    input  logic signed [ter_pkg::VERT_W-1:0]   vert0_x,
    input  logic signed [ter_pkg::VERT_W-1:0]   vert0_y,
    input  logic signed [ter_pkg::VERT_W-1:0]   vert1_x,
    input  logic signed [ter_pkg::VERT_W-1:0]   vert1_y,
    input  logic signed [ter_pkg::VERT_W-1:0]   vert2_x,
    input  logic signed [ter_pkg::VERT_W-1:0]   vert2_y,
    input  logic [ter_pkg::COLOR_W-1:0]         fill_color,
    // Result channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [ter_pkg::ADDR_W-1:0]          pixel_addr,
    output logic [ter_pkg::COLOR_W-1:0]         pixel_color,
    output logic                                write_enable,
    output logic                                box_done
);

    localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CLIP_W = ter_pkg::DIM_W + 1;
    localparam int OFS_W  = ter_pkg::OFS_W;
    localparam int STEP_W = ter_pkg::STEP_W;
    localparam int PROD_W = ter_pkg::PROD_W;
    localparam int EDGE_W = ter_pkg::EDGE_W;
    localparam int VERT_W = ter_pkg::VERT_W;
    localparam int COL_W  = ter_pkg::COLOR_W;
    localparam int AFW    = (YW + ter_pkg::DIM_W + 1 > ter_pkg::ADDR_W) ?
                            YW + ter_pkg::DIM_W + 1 : ter_pkg::ADDR_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ter_pkg::DIM_W-1:0] fb_width_reg;
    logic [ter_pkg::DIM_W-1:0] fb_height_reg;
    logic                      cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_width_reg  <= ter_pkg::FB_WIDTH_RST;
            fb_height_reg <= ter_pkg::FB_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                ter_pkg::REG_FB_WIDTH:  fb_width_reg  <= pwdata[ter_pkg::DIM_W-1:0];
                ter_pkg::REG_FB_HEIGHT: fb_height_reg <= pwdata[ter_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            ter_pkg::REG_FB_WIDTH:  prdata = ter_pkg::PDATA_W'(fb_width_reg);
            ter_pkg::REG_FB_HEIGHT: prdata = ter_pkg::PDATA_W'(fb_height_reg);
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic a_vld_reg, b_vld_reg, c_vld_reg;
    logic c_opc_reg;
    logic result_valid_reg;
    logic out_free, c_go, en_a, en_b, en_c;

    assign out_free   = !result_valid_reg || !result_stall;
    assign c_go       = c_vld_reg && (c_opc_reg == ter_pkg::OPC_LOAD || out_free);
    assign en_c       = !c_vld_reg || c_go;
    assign en_b       = !b_vld_reg || en_c;
    assign en_a       = !a_vld_reg || en_b;
    assign item_stall = !en_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                a_vld_reg <= item_valid;
            if (en_b)
                b_vld_reg <= a_vld_reg;
            if (en_c)
                c_vld_reg <= b_vld_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: input register
    // ------------------------------------------------------------------
    logic                     a_opc_reg;
    logic signed [VERT_W-1:0] a_vx_reg [3];
    logic signed [VERT_W-1:0] a_vy_reg [3];
    logic [COL_W-1:0]         a_color_reg;

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_opc_reg   <= opcode;
            a_vx_reg[0] <= vert0_x;
            a_vy_reg[0] <= vert0_y;
            a_vx_reg[1] <= vert1_x;
            a_vy_reg[1] <= vert1_y;
            a_vx_reg[2] <= vert2_x;
            a_vy_reg[2] <= vert2_y;
            a_color_reg <= fill_color;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: clipped bounding box and edge deltas
    // ------------------------------------------------------------------
    logic signed [VERT_W-1:0] mn_x, mx_x, mn_y, mx_y;
    logic [CLIP_W-1:0]        clip_w, clip_h;
    logic signed [OFS_W-1:0]  lim_x, lim_y;
    logic signed [OFS_W-1:0]  lo_x_s, hi_x_s, lo_y_s, hi_y_s;
    logic signed [OFS_W-1:0]  mx_x_s, mx_y_s;
    logic                     b_empty_next;
    logic signed [STEP_W-1:0] b_dx_next [3];
    logic signed [STEP_W-1:0] b_dy_next [3];

    always_comb
    begin
        // min and max of the three vertices
        mn_x = (a_vx_reg[0] < a_vx_reg[1]) ? a_vx_reg[0] : a_vx_reg[1];
        mn_x = (mn_x < a_vx_reg[2]) ? mn_x : a_vx_reg[2];
        mx_x = (a_vx_reg[0] > a_vx_reg[1]) ? a_vx_reg[0] : a_vx_reg[1];
        mx_x = (mx_x > a_vx_reg[2]) ? mx_x : a_vx_reg[2];
        mn_y = (a_vy_reg[0] < a_vy_reg[1]) ? a_vy_reg[0] : a_vy_reg[1];
        mn_y = (mn_y < a_vy_reg[2]) ? mn_y : a_vy_reg[2];
        mx_y = (a_vy_reg[0] > a_vy_reg[1]) ? a_vy_reg[0] : a_vy_reg[1];
        mx_y = (mx_y > a_vy_reg[2]) ? mx_y : a_vy_reg[2];

        // clip limits, capped at the maximum frame size
        clip_w = (CLIP_W'(fb_width_reg) < CLIP_W'(MAX_WIDTH)) ?
                 CLIP_W'(fb_width_reg) : CLIP_W'(MAX_WIDTH);
        clip_h = (CLIP_W'(fb_height_reg) < CLIP_W'(MAX_HEIGHT)) ?
                 CLIP_W'(fb_height_reg) : CLIP_W'(MAX_HEIGHT);
        lim_x  = $signed(OFS_W'(clip_w)) - OFS_W'(1);
        lim_y  = $signed(OFS_W'(clip_h)) - OFS_W'(1);

        mx_x_s = OFS_W'(mx_x);
        mx_y_s = OFS_W'(mx_y);
        lo_x_s = (mn_x < 0) ? '0 : OFS_W'(mn_x);
        lo_y_s = (mn_y < 0) ? '0 : OFS_W'(mn_y);
        hi_x_s = (mx_x_s > lim_x) ? lim_x : mx_x_s;
        hi_y_s = (mx_y_s > lim_y) ? lim_y : mx_y_s;
        b_empty_next = (lo_x_s > hi_x_s) || (lo_y_s > hi_y_s);

        // edge i runs from vertex i to vertex i+1
        for (int i = 0; i < 3; i++)
        begin
            b_dx_next[i] = STEP_W'(a_vx_reg[(i == 2) ? 0 : i + 1]) - STEP_W'(a_vx_reg[i]);
            b_dy_next[i] = STEP_W'(a_vy_reg[(i == 2) ? 0 : i + 1]) - STEP_W'(a_vy_reg[i]);
        end
    end

    logic                     b_opc_reg, b_empty_reg;
    logic [XW-1:0]            b_lo_x_reg, b_hi_x_reg;
    logic [YW-1:0]            b_lo_y_reg, b_hi_y_reg;
    logic signed [VERT_W-1:0] b_vx_reg [3];
    logic signed [VERT_W-1:0] b_vy_reg [3];
    logic signed [STEP_W-1:0] b_dx_reg [3];
    logic signed [STEP_W-1:0] b_dy_reg [3];
    logic [COL_W-1:0]         b_color_reg;

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            b_opc_reg   <= a_opc_reg;
            b_empty_reg <= b_empty_next;
            // box corners fit the coordinate width whenever the box is not empty
            b_lo_x_reg  <= lo_x_s[XW-1:0];
            b_hi_x_reg  <= hi_x_s[XW-1:0];
            b_lo_y_reg  <= lo_y_s[YW-1:0];
            b_hi_y_reg  <= hi_y_s[YW-1:0];
            b_vx_reg    <= a_vx_reg;
            b_vy_reg    <= a_vy_reg;
            b_dx_reg    <= b_dx_next;
            b_dy_reg    <= b_dy_next;
            b_color_reg <= a_color_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: edge products at the box corner
    // ------------------------------------------------------------------
    logic signed [OFS_W-1:0]  ofs_x [3];
    logic signed [OFS_W-1:0]  ofs_y [3];
    logic signed [PROD_W-1:0] c_px_next [3];
    logic signed [PROD_W-1:0] c_py_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ofs_x[i]     = $signed(OFS_W'(b_lo_x_reg)) - OFS_W'(b_vx_reg[i]);
            ofs_y[i]     = $signed(OFS_W'(b_lo_y_reg)) - OFS_W'(b_vy_reg[i]);
            c_px_next[i] = PROD_W'(ofs_x[i]) * PROD_W'(b_dy_reg[i]);
            c_py_next[i] = PROD_W'(ofs_y[i]) * PROD_W'(b_dx_reg[i]);
        end
    end

    logic                     c_empty_reg;
    logic [XW-1:0]            c_lo_x_reg, c_hi_x_reg;
    logic [YW-1:0]            c_lo_y_reg, c_hi_y_reg;
    logic signed [STEP_W-1:0] c_dx_reg [3];
    logic signed [STEP_W-1:0] c_dy_reg [3];
    logic signed [PROD_W-1:0] c_px_reg [3];
    logic signed [PROD_W-1:0] c_py_reg [3];
    logic [COL_W-1:0]         c_color_reg;

    always_ff @(posedge clk)
    begin
        if (en_c)
        begin
            c_opc_reg   <= b_opc_reg;
            c_empty_reg <= b_empty_reg;
            c_lo_x_reg  <= b_lo_x_reg;
            c_hi_x_reg  <= b_hi_x_reg;
            c_lo_y_reg  <= b_lo_y_reg;
            c_hi_y_reg  <= b_hi_y_reg;
            c_dx_reg    <= b_dx_reg;
            c_dy_reg    <= b_dy_reg;
            c_px_reg    <= c_px_next;
            c_py_reg    <= c_py_next;
            c_color_reg <= b_color_reg;
        end
    end

    // ------------------------------------------------------------------
    // Walker: triangle state, pixel test and incremental edge update
    // ------------------------------------------------------------------
    logic                     walk_active_reg, walk_active_next;
    logic [XW-1:0]            cur_x_reg, cur_x_next;
    logic [YW-1:0]            cur_y_reg, cur_y_next;
    logic [XW-1:0]            box_min_x_reg, box_min_x_next;
    logic [XW-1:0]            box_max_x_reg, box_max_x_next;
    logic [YW-1:0]            box_max_y_reg, box_max_y_next;
    logic signed [EDGE_W-1:0] edge_now_reg [3];
    logic signed [EDGE_W-1:0] edge_now_next [3];
    logic signed [EDGE_W-1:0] edge_row_reg [3];
    logic signed [EDGE_W-1:0] edge_row_next [3];
    logic signed [STEP_W-1:0] step_x_reg [3];
    logic signed [STEP_W-1:0] step_x_next [3];
    logic signed [STEP_W-1:0] step_y_reg [3];
    logic signed [STEP_W-1:0] step_y_next [3];
    logic [COL_W-1:0]         held_color_reg, held_color_next;

    logic                     all_pos, all_neg, last_pix, row_end;
    logic [AFW-1:0]           addr_full;

    // pixel test on the current edge values
    always_comb
    begin
        all_pos = 1'b1;
        all_neg = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            if (edge_now_reg[i][EDGE_W-1])
                all_pos = 1'b0;
            if (!edge_now_reg[i][EDGE_W-1] && edge_now_reg[i] != '0)
                all_neg = 1'b0;
        end
        row_end   = (cur_x_reg == box_max_x_reg);
        last_pix  = row_end && (cur_y_reg == box_max_y_reg);
        addr_full = AFW'(cur_y_reg) * AFW'(fb_width_reg) + AFW'(cur_x_reg);
    end

    // next walk state
    always_comb
    begin
        walk_active_next = walk_active_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        box_min_x_next   = box_min_x_reg;
        box_max_x_next   = box_max_x_reg;
        box_max_y_next   = box_max_y_reg;
        edge_now_next    = edge_now_reg;
        edge_row_next    = edge_row_reg;
        step_x_next      = step_x_reg;
        step_y_next      = step_y_reg;
        held_color_next  = held_color_reg;

        if (c_go && c_opc_reg == ter_pkg::OPC_LOAD)
        begin
            // new triangle drops any walk in progress
            held_color_next  = c_color_reg;
            walk_active_next = !c_empty_reg;
            if (!c_empty_reg)
            begin
                cur_x_next     = c_lo_x_reg;
                cur_y_next     = c_lo_y_reg;
                box_min_x_next = c_lo_x_reg;
                box_max_x_next = c_hi_x_reg;
                box_max_y_next = c_hi_y_reg;
                for (int i = 0; i < 3; i++)
                begin
                    edge_row_next[i] = EDGE_W'(c_px_reg[i]) - EDGE_W'(c_py_reg[i]);
                    edge_now_next[i] = edge_row_next[i];
                    step_x_next[i]   = c_dy_reg[i];
                    step_y_next[i]   = -c_dx_reg[i];
                end
            end
        end
        else if (c_go && walk_active_reg)
        begin
            if (last_pix)
            begin
                walk_active_next = 1'b0;
            end
            else if (row_end)
            begin
                cur_x_next = box_min_x_reg;
                cur_y_next = cur_y_reg + YW'(1);
                for (int i = 0; i < 3; i++)
                begin
                    edge_row_next[i] = edge_row_reg[i] + EDGE_W'(step_y_reg[i]);
                    edge_now_next[i] = edge_row_next[i];
                end
            end
            else
            begin
                cur_x_next = cur_x_reg + XW'(1);
                for (int i = 0; i < 3; i++)
                    edge_now_next[i] = edge_now_reg[i] + EDGE_W'(step_x_reg[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            walk_active_reg <= 1'b0;
        else
            walk_active_reg <= walk_active_next;
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg      <= cur_x_next;
        cur_y_reg      <= cur_y_next;
        box_min_x_reg  <= box_min_x_next;
        box_max_x_reg  <= box_max_x_next;
        box_max_y_reg  <= box_max_y_next;
        edge_now_reg   <= edge_now_next;
        edge_row_reg   <= edge_row_next;
        step_x_reg     <= step_x_next;
        step_y_reg     <= step_y_next;
        held_color_reg <= held_color_next;
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                      result_valid_next;
    logic                      res_load;
    logic [ter_pkg::ADDR_W-1:0] pixel_addr_reg, pixel_addr_next;
    logic [COL_W-1:0]          pixel_color_reg, pixel_color_next;
    logic                      write_enable_reg, write_enable_next;
    logic                      box_done_reg, box_done_next;

    assign res_load = c_go && c_opc_reg == ter_pkg::OPC_ADVANCE;

    always_comb
    begin
        result_valid_next = result_valid_reg && result_stall;
        if (res_load)
            result_valid_next = 1'b1;

        // an advance with no walk reports an idle, finished box
        if (walk_active_reg)
        begin
            pixel_addr_next   = addr_full[ter_pkg::ADDR_W-1:0];
            pixel_color_next  = held_color_reg;
            write_enable_next = all_pos || all_neg;
            box_done_next     = last_pix;
        end
        else
        begin
            pixel_addr_next   = '0;
            pixel_color_next  = '0;
            write_enable_next = 1'b0;
            box_done_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            pixel_addr_reg   <= pixel_addr_next;
            pixel_color_reg  <= pixel_color_next;
            write_enable_reg <= write_enable_next;
            box_done_reg     <= box_done_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign pixel_addr   = pixel_addr_reg;
    assign pixel_color  = pixel_color_reg;
    assign write_enable = write_enable_reg;
    assign box_done     = box_done_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // the walk position stays inside the box
    assert property (@(posedge clk) disable iff (!rst_n)
        walk_active_reg |-> (cur_x_reg <= box_max_x_reg && cur_y_reg <= box_max_y_reg &&
                             cur_x_reg >= box_min_x_reg))
        else $error("walk position left the bounding box");

    // an advance leaving the walker always shows up as a result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> result_valid)
        else $error("advance beat produced no result");

    // a blocked item in the last stage is held, not dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        (c_vld_reg && !c_go) |=> c_vld_reg)
        else $error("blocked item dropped from walker stage");

    // input is only stalled when the whole pipeline is full and the output is held
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (a_vld_reg && b_vld_reg && c_vld_reg && result_valid_reg &&
                        result_stall))
        else $error("input stalled with room in the pipeline");

endmodule

/* test/triangle_edge_rasterizer_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for triangle_edge_rasterizer: directed table, then random triangles.
// Depends on ter_pkg and the triangle_edge_rasterizer RTL; needs no other files.
module triangle_edge_rasterizer_tb;

    localparam int CLK_HALF    = 6;
    localparam int RST_CYCLES  = 7;
    localparam int RESULT_LAT  = 8;     // wait covering the pipeline, plus margin
    localparam int IDLE_LIMIT  = 3000;
    localparam int PHASE_ITEMS = 105;
    localparam int MAX_ADV     = 60;
    localparam int NUM_PHASES  = 13;
    localparam int CLIP_W      = ter_pkg::DEF_MAX_WIDTH;
    localparam int CLIP_H      = ter_pkg::DEF_MAX_HEIGHT;
    localparam int VERT_W      = ter_pkg::VERT_W;
    localparam int COLOR_W     = ter_pkg::COLOR_W;
    localparam int ADDR_W      = ter_pkg::ADDR_W;
    localparam int DIM_W       = ter_pkg::DIM_W;
    localparam int PADDR_W     = ter_pkg::PADDR_W;
    localparam int PDATA_W     = ter_pkg::PDATA_W;

    typedef struct packed {
        logic                          opc;
        logic [2:0][VERT_W-1:0]        vx;
        logic [2:0][VERT_W-1:0]        vy;
        logic [COLOR_W-1:0]            color;
    } tri_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic               we;
        logic               done;
    } pixel_t;

    typedef struct packed {
        tri_item_t it;
        logic      typed;
        pixel_t    want;
    } vec_row_t;

    // Clock and reset
    bit clk = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // DUT ports
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [PADDR_W-1:0] paddr        = '0;
    logic [PDATA_W-1:0] pwdata       = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               item_valid   = 1'b0;
    logic               item_stall;
    logic               opcode       = ter_pkg::OPC_ADVANCE;
    logic [VERT_W-1:0]  vert0_x      = '0;
    logic [VERT_W-1:0]  vert0_y      = '0;
    logic [VERT_W-1:0]  vert1_x      = '0;
    logic [VERT_W-1:0]  vert1_y      = '0;
    logic [VERT_W-1:0]  vert2_x      = '0;
    logic [VERT_W-1:0]  vert2_y      = '0;
    logic [COLOR_W-1:0] fill_color   = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic [ADDR_W-1:0]  pixel_addr;
    logic [COLOR_W-1:0] pixel_color;
    logic               write_enable;
    logic               box_done;

    triangle_edge_rasterizer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .opcode       (opcode),
        .vert0_x      (vert0_x),
        .vert0_y      (vert0_y),
        .vert1_x      (vert1_x),
        .vert1_y      (vert1_y),
        .vert2_x      (vert2_x),
        .vert2_y      (vert2_y),
        .fill_color   (fill_color),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pixel_addr   (pixel_addr),
        .pixel_color  (pixel_color),
        .write_enable (write_enable),
        .box_done     (box_done)
    );

    // Rasterizer state as predicted by the testbench
    logic [DIM_W-1:0]   width_reg  = ter_pkg::FB_WIDTH_RST;
    logic [DIM_W-1:0]   height_reg = ter_pkg::FB_HEIGHT_RST;
    bit                 walk_on    = 1'b0;
    int                 pix_x      = 0;
    int                 pix_y      = 0;
    int                 box_x0     = 0;
    int                 box_x1     = 0;
    int                 box_y1     = 0;
    longint             edge_val[3];
    longint             edge_row[3];
    longint             step_col[3];
    longint             step_row[3];
    logic [COLOR_W-1:0] color_q    = '0;

    pixel_t   pixel_q[$];
    vec_row_t vec_q[$];
    int       err_cnt     = 0;
    int       idle_cycles = 0;
    int       burst_left  = 0;

    // Receiver stall pattern and long hold-off
    bit hold_req   = 1'b0;
    int hold_left  = 0;
    int stall_mode = 0;
    int mode_left  = 0;

    pixel_t mon_got;
    pixel_t mon_want;

    // Load: clip the bounding box and set up the edge values at its corner
    function automatic void rast_load(tri_item_t it);
        longint x[3];
        longint y[3];
        longint lo_x, hi_x, lo_y, hi_y, cw, ch, ddx, ddy;
        int     j;
        for (int i = 0; i < 3; i++)
        begin
            x[i] = longint'($signed(it.vx[i]));
            y[i] = longint'($signed(it.vy[i]));
        end
        color_q = it.color;
        cw = (width_reg < CLIP_W) ? longint'(width_reg) : CLIP_W;
        ch = (height_reg < CLIP_H) ? longint'(height_reg) : CLIP_H;
        lo_x = x[0]; hi_x = x[0]; lo_y = y[0]; hi_y = y[0];
        for (int i = 1; i < 3; i++)
        begin
            if (x[i] < lo_x) lo_x = x[i];
            if (x[i] > hi_x) hi_x = x[i];
            if (y[i] < lo_y) lo_y = y[i];
            if (y[i] > hi_y) hi_y = y[i];
        end
        if (lo_x < 0) lo_x = 0;
        if (lo_y < 0) lo_y = 0;
        if (hi_x > cw - 1) hi_x = cw - 1;
        if (hi_y > ch - 1) hi_y = ch - 1;
        walk_on = 1'b0;
        if (lo_x > hi_x || lo_y > hi_y)
            return;
        for (int i = 0; i < 3; i++)
        begin
            j = (i + 1) % 3;
            ddx = x[j] - x[i];
            ddy = y[j] - y[i];
            step_col[i] = ddy;
            step_row[i] = -ddx;
            edge_row[i] = (lo_x - x[i]) * ddy - (lo_y - y[i]) * ddx;
            edge_val[i] = edge_row[i];
        end
        box_x0  = int'(lo_x);
        box_x1  = int'(hi_x);
        box_y1  = int'(hi_y);
        pix_x   = int'(lo_x);
        pix_y   = int'(lo_y);
        walk_on = 1'b1;
    endfunction

    // Advance: test the current pixel, then step in row-major order
    function automatic pixel_t rast_advance();
        pixel_t r;
        bit     all_pos, all_neg, last;
        longint lin;
        if (!walk_on)
        begin
            r.addr  = '0;
            r.color = '0;
            r.we    = 1'b0;
            r.done  = 1'b1;
            return r;
        end
        all_pos = edge_val[0] >= 0 && edge_val[1] >= 0 && edge_val[2] >= 0;
        all_neg = edge_val[0] <= 0 && edge_val[1] <= 0 && edge_val[2] <= 0;
        last    = pix_x == box_x1 && pix_y == box_y1;
        lin     = longint'(pix_y) * longint'(width_reg) + longint'(pix_x);
        r.addr  = lin[ADDR_W-1:0];
        r.color = color_q;
        r.we    = all_pos || all_neg;
        r.done  = last;
        if (last)
            walk_on = 1'b0;
        else if (pix_x == box_x1)
        begin
            pix_x = box_x0;
            pix_y = pix_y + 1;
            for (int i = 0; i < 3; i++)
            begin
                edge_row[i] += step_row[i];
                edge_val[i] = edge_row[i];
            end
        end
        else
        begin
            pix_x = pix_x + 1;
            for (int i = 0; i < 3; i++)
                edge_val[i] += step_col[i];
        end
        return r;
    endfunction

    function automatic void add_row(logic opc, int x0, int y0, int x1, int y1, int x2, int y2,
                                    logic [COLOR_W-1:0] color, logic typed,
                                    logic [ADDR_W-1:0] w_addr, logic [COLOR_W-1:0] w_color,
                                    logic w_we, logic w_done);
        vec_row_t row;
        row.it.opc   = opc;
        row.it.vx[0] = 16'(x0); row.it.vy[0] = 16'(y0);
        row.it.vx[1] = 16'(x1); row.it.vy[1] = 16'(y1);
        row.it.vx[2] = 16'(x2); row.it.vy[2] = 16'(y2);
        row.it.color = color;
        row.typed    = typed;
        row.want     = {w_addr, w_color, w_we, w_done};
        vec_q.push_back(row);
    endfunction

    // Small triangle near the visible area, now and then a large one
    function automatic tri_item_t rand_load(int cw, int ch);
        tri_item_t it;
        int        sel, span, bx, by, v;
        it.opc   = ter_pkg::OPC_LOAD;
        it.color = $urandom;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            span = $urandom_range(0, 6);
        else if (sel < 9)
            span = $urandom_range(0, 40);
        else
            span = cw + ch + 8;
        bx = int'($urandom_range(0, cw + 6)) - 3;
        by = int'($urandom_range(0, ch + 6)) - 3;
        for (int i = 0; i < 3; i++)
        begin
            v = bx + int'($urandom_range(0, span)) - span / 2;
            it.vx[i] = v[VERT_W-1:0];
            v = by + int'($urandom_range(0, span)) - span / 2;
            it.vy[i] = v[VERT_W-1:0];
        end
        return it;
    endfunction

    // Any opcode, every field at full range
    function automatic tri_item_t rand_item(logic opc);
        tri_item_t it;
        it.opc = opc;
        for (int i = 0; i < 3; i++)
        begin
            it.vx[i] = VERT_W'($urandom);
            it.vy[i] = VERT_W'($urandom);
        end
        it.color = $urandom;
        return it;
    endfunction

    // Offer one beat, hold it until taken, then predict. Starts and ends at a falling edge.
    task automatic send_item(tri_item_t it, bit typed, pixel_t want);
        int     gap;
        pixel_t p;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        opcode     <= it.opc;
        vert0_x    <= it.vx[0];
        vert0_y    <= it.vy[0];
        vert1_x    <= it.vx[1];
        vert1_y    <= it.vy[1];
        vert2_x    <= it.vx[2];
        vert2_y    <= it.vy[2];
        fill_color <= it.color;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        if (it.opc == ter_pkg::OPC_LOAD)
            rast_load(it);
        else
        begin
            p = rast_advance();
            if (typed)
                p = want;
            pixel_q.push_back(p);
        end
        @(negedge clk);
    endtask

    // Stop sending, let every result drain, then cover the latency of trailing loads
    task automatic wait_idle();
        item_valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (RESULT_LAT) @(posedge clk);
        @(negedge clk);
    endtask

    // Register write, then read back. Starts and ends at a falling edge.
    task automatic write_reg(logic idx, logic [DIM_W-1:0] value);
        logic [PDATA_W-1:0] data;
        data = $urandom;
        data[DIM_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == ter_pkg::REG_FB_WIDTH)
            width_reg = value;
        else
            height_reg = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {{(PDATA_W-DIM_W){1'b0}}, value})
        begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("readback reg %0d: expected %0d, got %0h", idx, value, prdata);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Receiver: long hold-off on request, else a stall pattern that changes mode
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = $urandom_range(60, 100);
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(20, 150);
            end
            mode_left--;
            case (stall_mode)
                0:       result_stall <= 1'b0;
                1:       result_stall <= ($urandom_range(0, 3) == 0);
                default: result_stall <= ($urandom_range(0, 1) == 1);
            endcase
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            mon_got = {pixel_addr, pixel_color, write_enable, box_done};
            if (pixel_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected beat: addr %0d color %h we %b done %b",
                             pixel_addr, pixel_color, write_enable, box_done);
            end
            else
            begin
                mon_want = pixel_q.pop_front();
                if (mon_got !== mon_want)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: addr %0d/%0d color %h/%h we %b/%b done %b/%b (exp/act)",
                                 mon_want.addr, mon_got.addr, mon_want.color, mon_got.color,
                                 mon_want.we, mon_got.we, mon_want.done, mon_got.done);
                end
            end
        end
    end

    // Watchdog on cycles without any progress
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** triangle_edge_rasterizer: FAILED **");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        int        ph_w[NUM_PHASES];
        int        ph_h[NUM_PHASES];
        int        cw, ch, sent, nbox, nadv;
        tri_item_t it;
        vec_row_t  row;
        pixel_t    none;

        ph_w = '{16, 1, 4096, 8191, 0, 9, 33, 4097, 5, 64, 2, 13, 800};
        ph_h = '{12, 1, 4096, 8191, 9, 0, 7, 3, 4096, 48, 2, 8191, 600};
        none = '0;
        for (int i = 0; i < 3; i++)
        begin
            edge_val[i] = 0; edge_row[i] = 0; step_col[i] = 0; step_row[i] = 0;
        end

        // Directed table, run at the reset frame size of 800 x 600
        // idle after reset
        add_row(ter_pkg::OPC_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1);
        // one-pixel degenerate triangle at the origin, then idle again
        add_row(ter_pkg::OPC_LOAD, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        add_row(ter_pkg::OPC_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 1, 0, 32'hFFFF_FFFF, 1, 1);
        add_row(ter_pkg::OPC_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1);
        // one pixel at the far corner of the frame
        add_row(ter_pkg::OPC_LOAD, 799, 599, 799, 599, 799, 599, 32'h1234_5678,
                0, 0, 0, 0, 0);
        add_row(ter_pkg::OPC_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 1, 24'd479999, 32'h1234_5678,
                1, 1);
        // vertex extremes, box clipped to the whole frame
        add_row(ter_pkg::OPC_LOAD, -32768, -32768, 32767, -32768, -32768, 32767, 0,
                0, 0, 0, 0, 0);
        add_row(ter_pkg::OPC_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ter_pkg::OPC_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // box entirely left/above the frame: empty
        add_row(ter_pkg::OPC_LOAD, -32768, -5, -1, -1, -7, -32768, 32'hAAAA_5555,
                0, 0, 0, 0, 0);
        add_row(ter_pkg::OPC_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1);
        // box entirely right of the frame: empty
        add_row(ter_pkg::OPC_LOAD, 800, 0, 32767, 10, 900, 599, 32'h5555_AAAA,
                0, 0, 0, 0, 0);
        add_row(ter_pkg::OPC_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1);
        // one winding, then a load mid-walk with the other winding
        add_row(ter_pkg::OPC_LOAD, 0, 0, 3, 0, 0, 3, 32'h0000_FF00, 0, 0, 0, 0, 0);
        for (int i = 0; i < 3; i++)
            add_row(ter_pkg::OPC_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ter_pkg::OPC_LOAD, 0, 0, 0, 3, 3, 0, 32'h00FF_0000, 0, 0, 0, 0, 0);
        for (int i = 0; i < 4; i++)
            add_row(ter_pkg::OPC_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // collinear vertices
        add_row(ter_pkg::OPC_LOAD, 2, 2, 4, 4, 6, 6, 32'h5A5A_5A5A, 0, 0, 0, 0, 0);
        add_row(ter_pkg::OPC_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        repeat (RST_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (vec_q[i])
        begin
            row = vec_q[i];
            send_item(row.it, row.typed, row.want);
        end

        // Random phases over a range of frame sizes
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_idle();
            write_reg(ter_pkg::REG_FB_WIDTH, ph_w[ph][DIM_W-1:0]);
            write_reg(ter_pkg::REG_FB_HEIGHT, ph_h[ph][DIM_W-1:0]);
            cw = (ph_w[ph] < CLIP_W) ? ph_w[ph] : CLIP_W;
            ch = (ph_h[ph] < CLIP_H) ? ph_h[ph] : CLIP_H;
            sent = 0;

            // back-pressure: receiver holds off while the sender keeps going, then full drain
            if (ph == 0 || ph == 9)
            begin
                send_item(rand_load(cw, ch), 1'b0, none);
                hold_req = 1'b1;
                for (int i = 0; i < 40; i++)
                    send_item(rand_item(ter_pkg::OPC_ADVANCE), 1'b0, none);
                wait_idle();
                sent += 41;
            end

            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_item(rand_item(1'($urandom_range(0, 1))), 1'b0, none);
                    sent++;
                end
                else
                begin
                    it = rand_load(cw, ch);
                    send_item(it, 1'b0, none);
                    nbox = walk_on ? (box_x1 - box_x0 + 1) * (box_y1 - pix_y + 1) : 0;
                    if (nbox > MAX_ADV)
                        nbox = MAX_ADV;
                    if ($urandom_range(0, 3) == 0)
                        nadv = $urandom_range(0, nbox);
                    else
                        nadv = nbox + $urandom_range(0, 2);
                    for (int i = 0; i < nadv; i++)
                        send_item(rand_item(ter_pkg::OPC_ADVANCE), 1'b0, none);
                    sent += nadv + 1;
                end
            end
        end

        wait_idle();
        if (err_cnt == 0 && pixel_q.size() == 0)
            $display("** triangle_edge_rasterizer: PASSED **");
        else
            $display("** triangle_edge_rasterizer: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
src/ter_pkg.sv
src/triangle_edge_rasterizer.sv
test/triangle_edge_rasterizer_tb.sv
